FILE: rtl/core/ols_pkg.sv
// Shared types, codes and constants for the ordered list block.
`default_nettype none

package ols_pkg;

    // Fixed field widths of the channel beats
    localparam int KIND_BITS     = 2;
    localparam int IN_VALUE_BITS = 32;
    localparam int POS_BITS      = 8;
    localparam int COUNT_BITS    = 7;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_HEAD   = 2'd0,
        KIND_TAIL   = 2'd1,
        KIND_POS    = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_BOUNDS  = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input beat
        logic start;     // latch status, target and walk start
        logic rd_prev;   // read the slot below the walk index
        logic shift_wr;  // move read word one slot toward the tail
        logic place;     // write the new word at the target slot
        logic scan_cmp;  // compare read word, step the walk
        logic emit;      // load the output register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_search;
        logic reject;
        logic idx_at_tgt;
        logic idx_at_count;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ols_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface ols_cmd_if;
    import ols_pkg::*;

    logic                             valid;
    logic                             ready;
    kind_t                            kind;
    logic signed [IN_VALUE_BITS-1:0]  value;
    logic        [POS_BITS-1:0]       position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface ols_rsp_if;
    import ols_pkg::*;

    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic                    found;
    logic [COUNT_BITS-1:0]   entry_count;

    modport source (output valid, output status, output found, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ols_ctrl.sv
// Sequencing state machine for the ordered list block.
`default_nettype none

module ols_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ols_pkg::dp_stat_t stat,
    output ols_pkg::ctl_cmd_t ctl
);
    import ols_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.reject)
                    state_next = S_DONE;
                else if (stat.is_search)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                state_next = stat.idx_at_tgt ? S_PLACE : S_SHIFT_WR;
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_PLACE:    state_next = S_DONE;
            S_SCAN_RD:
            begin
                // stop at the end of the list or on the first match
                if (stat.idx_at_count || stat.hit)
                    state_next = S_DONE;
                else
                    state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: state_next = S_SCAN_RD;
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            S_CHECK:    ctl.start    = 1'b1;
            S_SHIFT_RD: ctl.rd_prev  = 1'b1;
            S_SHIFT_WR: ctl.shift_wr = 1'b1;
            S_PLACE:    ctl.place    = 1'b1;
            S_SCAN_RD:  ctl.rd_prev  = 1'b0;
            S_SCAN_CMP: ctl.scan_cmp = 1'b1;
            S_DONE:     ctl.emit     = stat.out_free;
            default:    ctl          = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ols_dp.sv
// Entry store, walk index, status decode and output register.
`default_nettype none

module ols_dp #(
    parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ols_pkg::VALUE_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  ols_pkg::ctl_cmd_t                         ctl,
    output ols_pkg::dp_stat_t                         stat,
    input  ols_pkg::kind_t                            in_kind,
    input  logic signed [ols_pkg::IN_VALUE_BITS-1:0]  in_value,
    input  logic        [ols_pkg::POS_BITS-1:0]       in_position,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output ols_pkg::status_t                          out_status,
    output logic                                      out_found,
    output logic        [ols_pkg::COUNT_BITS-1:0]     out_entry_count
);
    import ols_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;
    localparam int EXT_W  = 64;

    // Entry store
    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;

    // Item and walk state
    kind_t                 kind_reg;
    logic [VALUE_BITS-1:0] word_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_dec;
    logic [CNT_W-1:0]      tgt_reg;
    logic                  hit_reg;
    status_t               status_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic                  out_found_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    logic signed [EXT_W-1:0] value_ext;
    logic [VALUE_BITS-1:0]   word_in;
    logic                    full;
    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        lim_w;
    status_t                 status_calc;
    logic [CNT_W-1:0]        tgt_calc;
    logic [CNT_W-1:0]        idx_start;

    // sign extend, then keep the low word
    assign value_ext = EXT_W'(in_value);
    assign word_in   = value_ext[VALUE_BITS-1:0];

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign pos_w = CMP_W'(pos_reg);
    assign lim_w = CMP_W'(count_reg) + CMP_W'(1);

    always_comb
    begin
        status_calc = STAT_OK;
        tgt_calc    = '0;
        idx_start   = count_reg;
        case (kind_reg)
            KIND_SEARCH:
            begin
                idx_start = '0;
            end
            KIND_POS:
            begin
                // zero first, then bounds, then full
                if (pos_reg == '0)
                    status_calc = STAT_INVALID;
                else if (pos_w > lim_w)
                    status_calc = STAT_BOUNDS;
                else if (full)
                    status_calc = STAT_FULL;
                tgt_calc = CNT_W'(pos_w - CMP_W'(1));
            end
            KIND_TAIL:
            begin
                if (full)
                    status_calc = STAT_FULL;
                tgt_calc = count_reg;
            end
            default:
            begin
                if (full)
                    status_calc = STAT_FULL;
            end
        endcase
    end

    assign idx_dec = idx_reg - CNT_W'(1);
    assign rd_addr = ctl.rd_prev ? idx_dec[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_en   = ctl.shift_wr | ctl.place;
    assign wr_addr = ctl.place ? tgt_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data = ctl.place ? word_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            kind_reg <= in_kind;
            word_reg <= word_in;
            pos_reg  <= in_position;
        end
        if (ctl.start)
        begin
            status_reg <= status_calc;
            tgt_reg    <= tgt_calc;
            idx_reg    <= idx_start;
            hit_reg    <= 1'b0;
        end
        else if (ctl.shift_wr)
        begin
            idx_reg <= idx_dec;
        end
        else if (ctl.scan_cmp)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (rd_data_reg == word_reg)
                hit_reg <= 1'b1;
        end
        if (ctl.emit)
        begin
            out_status_reg <= status_reg;
            out_found_reg  <= hit_reg;
            out_count_reg  <= COUNT_BITS'(count_reg);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.place)
            count_next = count_reg + CNT_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.is_search    = (kind_reg == KIND_SEARCH);
    assign stat.reject       = (status_calc != STAT_OK);
    assign stat.idx_at_tgt   = (idx_reg == tgt_reg);
    assign stat.idx_at_count = (idx_reg == count_reg);
    assign stat.hit          = hit_reg;
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_found       = out_found_reg;
    assign out_entry_count = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.place |-> !full)
        else $error("write into a full list");

    a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.place |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("count did not step on insert");

    a_shift_above_tgt: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_wr |-> (idx_reg > tgt_reg))
        else $error("shift at or below insert point");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> out_valid_reg)
        else $error("result register not loaded");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_insert_search.sv
// Top level of the bounded ordered list with insert and search.
//
//  channel | dir | beat fields                       | handshake
//  --------+-----+-----------------------------------+-------------
//  cmd     | in  | kind, value, position             | valid/ready
//  rsp     | out | status, found, entry_count        | valid/ready
//
//  An insert moves each entry from the tail down to the insert point one
//  slot toward the tail, then places the new word; a search walks from the
//  head and ends early on a match. Each moved word takes a read and a write
//  step in the entry store, each compared word a read and a compare step.
//  Reset empties the list at once; the entry words themselves are not cleared.
//  The result waits in an output register; a stalled rsp holds the finished
//  beat and the next cmd beat is held off only at the final hand-over.
`default_nettype none

module ordered_list_insert_search #(
    parameter int CAPACITY   = ols_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ols_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ols_cmd_if.sink           cmd,
    ols_rsp_if.source         rsp
);
    import ols_pkg::*;

    ctl_cmd_t ctl;   // sequencer commands
    dp_stat_t stat;  // datapath flags back to the sequencer
    logic     in_ready;

    // State machine: one item at a time, walks the store slot by slot
    ols_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    assign cmd.ready = in_ready;

    // Store, count, status decode and result register
    ols_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .in_kind         (cmd.kind),
        .in_value        (cmd.value),
        .in_position     (cmd.position),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_status      (rsp.status),
        .out_found       (rsp.found),
        .out_entry_count (rsp.entry_count)
    );

endmodule

`default_nettype wire

FILE: dv/ordered_list_insert_search_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ordered list: directed corner beats, then random insert/search.
module ordered_list_insert_search_test;
    import ols_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RANDOM_BEATS = 1400;
    // no idling on either side for the tail end of the random part
    localparam int QUIET_BEATS  = 200;
    // longest single operation is a full-length shift or scan, plus slack
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 40;
    // worst case per beat (full-length operation, longest rsp stall and cmd gap), with margin
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        status_t               status;
        logic                  found;
        logic [COUNT_BITS-1:0] entry_count;
    } list_result_t;

    // Shadow copy of the list plus the queue of results still owed by the block.
    class ListScoreboard;
        logic [VALUE_BITS-1:0] held[$];
        list_result_t          awaited[$];
        int                    mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int unsigned occupancy();
            return held.size();
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Apply one accepted cmd beat to the shadow list and queue its result.
        function void note_request(kind_t kind, logic [IN_VALUE_BITS-1:0] value,
                                   logic [POS_BITS-1:0] position);
            logic [63:0]           wide;
            logic [VALUE_BITS-1:0] word;
            list_result_t          res;
            int                    n;
            wide = {{(64 - IN_VALUE_BITS){value[IN_VALUE_BITS-1]}}, value};
            word = wide[VALUE_BITS-1:0];
            n = held.size();
            res.status = STAT_OK;
            res.found  = 1'b0;
            case (kind)
                KIND_SEARCH:
                begin
                    foreach (held[i])
                        if (held[i] == word)
                            res.found = 1'b1;
                end
                KIND_POS:
                begin
                    // zero first, then bounds, then full
                    if (position == '0)
                        res.status = STAT_INVALID;
                    else if (int'(position) > n + 1)
                        res.status = STAT_BOUNDS;
                    else if (n >= CAPACITY)
                        res.status = STAT_FULL;
                    else
                        held.insert(int'(position) - 1, word);
                end
                default:
                begin
                    if (n >= CAPACITY)
                        res.status = STAT_FULL;
                    else if (kind == KIND_HEAD)
                        held.push_front(word);
                    else
                        held.push_back(word);
                end
            endcase
            res.entry_count = COUNT_BITS'(held.size());
            awaited.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_response(status_t status, logic found, logic [COUNT_BITS-1:0] entry_count);
            list_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected rsp beat status=%0d found=%b count=%0d",
                                          status, found, entry_count));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (found !== want.found)
                report_mismatch($sformatf("found %b, expected %b", found, want.found));
            if (entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, expected %0d",
                                          entry_count, want.entry_count));
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    bit             quiet = 1'b0;     // set for the last stretch: no idling anywhere
    int             gap_pct = 0;      // chance of a cmd gap before a beat, re-rolled now and then
    int unsigned    cycles = 0;
    ListScoreboard  tracker = new();

    ols_cmd_if cmd();
    ols_rsp_if rsp();

    ordered_list_insert_search #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // rsp monitor: ready is ours and was set last edge, valid and fields are
    // read before this edge's updates land, so sampling here is race free.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            tracker.check_response(rsp.status, rsp.found, rsp.entry_count);
    end

    // rsp side back-pressure: random stall bursts between open stretches
    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Present one cmd beat and hold it until accepted; called at a rising edge
    // and returns at the edge of acceptance. valid stays high for back-to-back beats.
    task automatic send_request(kind_t kind, logic [IN_VALUE_BITS-1:0] value,
                                logic [POS_BITS-1:0] position);
        if (!quiet && $urandom_range(0, 99) < gap_pct)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.kind     <= kind;
        cmd.value    <= value;
        cmd.position <= position;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        tracker.note_request(kind, value, position);
    endtask

    // Sender holds off until every owed result has come back
    task automatic hold_until_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [IN_VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]      position;
        kind_t                    kind;
        int unsigned              n;
        int unsigned              pick;
        logic [IN_VALUE_BITS-1:0] extremes [4];

        extremes[0] = 32'h8000_0000;
        extremes[1] = 32'h7fff_ffff;
        extremes[2] = 32'h0000_0000;
        extremes[3] = 32'hffff_ffff;

        rst_n        <= 1'b0;
        cmd.valid    <= 1'b0;
        cmd.kind     <= KIND_HEAD;
        cmd.value    <= '0;
        cmd.position <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        send_request(KIND_SEARCH, 32'h0000_0000, 8'd0);    // search on empty list
        send_request(KIND_POS,    32'h1111_1111, 8'd0);    // position zero rejected
        send_request(KIND_POS,    32'h2222_2222, 8'd2);    // past the end of an empty list
        send_request(KIND_POS,    32'h7fff_ffff, 8'd1);    // position 1 into empty list
        send_request(KIND_HEAD,   32'h8000_0000, 8'hff);   // position ignored off kind POS
        send_request(KIND_TAIL,   32'hffff_ffff, 8'd0);
        send_request(KIND_POS,    32'h0000_0000, 8'd4);    // count+1 appends at the tail
        send_request(KIND_POS,    32'h1234_5678, 8'd2);    // into the middle
        send_request(KIND_POS,    32'hdead_beef, 8'd1);    // position 1 acts as head insert
        send_request(KIND_POS,    32'h0000_0000, 8'd8);    // count+2: out of bounds
        send_request(KIND_POS,    32'h0000_0000, 8'hff);
        send_request(KIND_SEARCH, 32'h8000_0000, 8'hff);
        send_request(KIND_SEARCH, 32'h7fff_ffff, 8'd0);
        send_request(KIND_SEARCH, 32'hffff_ffff, 8'd0);
        send_request(KIND_SEARCH, 32'h0000_0000, 8'd0);
        send_request(KIND_SEARCH, 32'hdead_beef, 8'd0);
        send_request(KIND_SEARCH, 32'h0000_0001, 8'd0);    // near misses
        send_request(KIND_SEARCH, 32'h7fff_fffe, 8'd0);
        send_request(KIND_TAIL,   32'h0000_0000, 8'd0);    // duplicate word
        send_request(KIND_SEARCH, 32'h0000_0000, 8'd0);
        hold_until_drained();

        // ---- random part ----
        // Inserts are kept rare so the list fills slowly and searches see many lengths;
        // once full, every insert past the zero and bounds checks should come back flagged full.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            end
            if (i == RANDOM_BEATS - QUIET_BEATS)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 99) == 0)
                hold_until_drained();

            n        = tracker.occupancy();
            pick     = $urandom_range(0, 99);
            value    = $urandom;
            position = POS_BITS'($urandom);
            case ($urandom_range(0, 7))
                0:       value = extremes[$urandom_range(0, 3)];
                1, 2:    if (n != 0) value = tracker.held[$urandom_range(0, n - 1)];
                default: ;
            endcase

            if (pick < 2)
                kind = KIND_HEAD;
            else if (pick < 4)
                kind = KIND_TAIL;
            else if (pick < 7)
            begin
                kind     = KIND_POS;
                position = POS_BITS'($urandom_range(1, n + 1));
            end
            else if (pick < 11)
            begin
                kind     = KIND_POS;
                position = '0;
            end
            else if (pick < 18)
            begin
                kind     = KIND_POS;
                position = POS_BITS'($urandom_range(n + 2, 255));
            end
            else
            begin
                // searches: half aimed at held words, some of those one bit off
                kind = KIND_SEARCH;
                if (n != 0 && $urandom_range(0, 1) == 0)
                begin
                    value = tracker.held[$urandom_range(0, n - 1)];
                    if ($urandom_range(0, 3) == 0)
                        value[$urandom_range(0, IN_VALUE_BITS - 1)] ^= 1'b1;
                end
            end
            send_request(kind, value, position);
        end

        // Make sure the full list is reached, then its check order
        while (tracker.occupancy() < CAPACITY)
            send_request(KIND_TAIL, $urandom, POS_BITS'($urandom));
        send_request(KIND_POS,    $urandom, 8'd0);                   // zero beats full
        send_request(KIND_POS,    $urandom, POS_BITS'(CAPACITY + 2)); // bounds beats full
        send_request(KIND_POS,    $urandom, POS_BITS'(CAPACITY + 1)); // full
        send_request(KIND_HEAD,   $urandom, POS_BITS'($urandom));
        send_request(KIND_TAIL,   $urandom, POS_BITS'($urandom));
        send_request(KIND_SEARCH, tracker.held[CAPACITY - 1], POS_BITS'($urandom));
        send_request(KIND_SEARCH, tracker.held[0], POS_BITS'($urandom));

        // ---- wind down ----
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ols_pkg.sv
rtl/core/ols_if.sv
rtl/core/ols_ctrl.sv
rtl/core/ols_dp.sv
rtl/core/ordered_list_insert_search.sv
dv/ordered_list_insert_search_test.sv
